// ===== rtl/ppr_pkg.sv =====
// ----------------------------------------------------------------------------
// ppr_pkg
// shared types and constants for the partition function ratio pipeline
// ----------------------------------------------------------------------------
package ppr_pkg;

  localparam int TEMP_W  = 20;
  localparam int COEF_W  = 48;
  localparam int RATIO_W = 32;
  localparam int STAT_W  = 2;
  localparam int FRAC_W  = 24;
  localparam int NREGS   = 4;
  localparam int DIV_BPS = 2;   // quotient bits per divider stage

  typedef enum logic [1:0] {
    ST_OK      = 2'd0,
    ST_NONE    = 2'd1,
    ST_DIVZERO = 2'd2,
    ST_SAT     = 2'd3
  } status_t;

  typedef enum logic [2:0] {
    REG_MODE  = 3'd0,
    REG_C0    = 3'd1,
    REG_C1    = 3'd2,
    REG_C2    = 3'd3,
    REG_C3    = 3'd4
  } reg_idx_t;

  localparam logic [RATIO_W-1:0] RATIO_ONE = 32'h0100_0000;
  localparam logic [RATIO_W-1:0] RATIO_MAX = 32'hFFFF_FFFF;

  // early decision carried alongside the divider
  typedef struct packed {
    logic    done;
    status_t status;
    logic [RATIO_W-1:0] ratio;
  } pre_t;

endpackage

// ===== rtl/ppr_horner.sv =====
// ----------------------------------------------------------------------------
// ppr_horner
// pipelined horner evaluation of p(t) at a common scale, two stages per step
// ----------------------------------------------------------------------------
module ppr_horner #(
  parameter int NUM_COEFFS = 4,
  parameter int ACC_W      = 48 + 28 * NUM_COEFFS
) (
  input  logic                            clk,
  input  logic                            en,
  input  logic [ppr_pkg::TEMP_W-1:0]      t_in,
  input  logic [NUM_COEFFS*ppr_pkg::COEF_W-1:0] coefs,
  output logic signed [ACC_W-1:0]         acc_out
);
  import ppr_pkg::*;

  localparam int LIMB_W = 32;
  localparam int NLIMB  = (ACC_W + LIMB_W - 1) / LIMB_W;
  localparam int PAD_W  = NLIMB * LIMB_W;
  localparam int PP_W   = LIMB_W + TEMP_W;

  logic [TEMP_W-1:0]      t_r   [NUM_COEFFS];
  logic signed [ACC_W-1:0] acc_r [NUM_COEFFS];

  // step s adds coefficient of order NUM_COEFFS-1-s
  // first stage: limb products acc * t, second stage: sum plus term
  // the product is only needed modulo 2^ACC_W, so limbs multiply unsigned
  for (genvar s = 0; s < NUM_COEFFS; s++) begin : g_stage
    logic [ACC_W-1:0]        prev;
    logic [PAD_W-1:0]        prev_pad;
    logic [TEMP_W-1:0]       t_prev;
    logic [PP_W-1:0]         pp_r [NLIMB];
    logic [TEMP_W-1:0]       tm_r;
    logic [ACC_W-1:0]        sum;
    logic signed [ACC_W-1:0] term;
    logic signed [ACC_W-1:0] acc_nxt;
    if (s == 0) begin : g_first
      assign prev   = '0;
      assign t_prev = t_in;
    end else begin : g_next
      assign prev   = acc_r[s-1];
      assign t_prev = t_r[s-1];
    end
    assign prev_pad = PAD_W'(prev);
    assign term = ACC_W'($signed(coefs[(NUM_COEFFS-1-s)*COEF_W +: COEF_W]))
                  <<< (8 * s);
    always_comb begin
      sum = '0;
      for (int j = 0; j < NLIMB; j++) begin
        sum = sum + ACC_W'(PAD_W'(pp_r[j]) << (j * LIMB_W));
      end
    end
    assign acc_nxt = $signed(sum) + term;
    always_ff @(posedge clk) begin
      if (en) begin
        for (int j = 0; j < NLIMB; j++) begin
          pp_r[j] <= prev_pad[j*LIMB_W +: LIMB_W] * t_prev;
        end
        tm_r     <= t_prev;
        acc_r[s] <= acc_nxt;
        t_r[s]   <= tm_r;
      end
    end
  end

  assign acc_out = acc_r[NUM_COEFFS-1];
endmodule

// ===== rtl/ppr_divider.sv =====
// ----------------------------------------------------------------------------
// ppr_divider
// pipelined restoring divider, DIV_BPS quotient bits per stage
// ----------------------------------------------------------------------------
module ppr_divider #(
  parameter int MAG_W = 160
) (
  input  logic                       clk,
  input  logic                       en,
  input  logic [MAG_W-1:0]           num,
  input  logic [MAG_W-1:0]           den,
  output logic [ppr_pkg::RATIO_W-1:0] quot
);
  import ppr_pkg::*;

  localparam int BPS   = DIV_BPS;
  localparam int NSTG  = RATIO_W / BPS;
  localparam int REM_W = MAG_W + 1;

  // num < den*256 so quotient fits 32 bits; start with rem = num >> 8
  logic [REM_W-1:0]   rem_r [NSTG];
  logic [MAG_W-1:0]   den_r [NSTG];
  logic [RATIO_W-1:0] q_r   [NSTG];
  logic [RATIO_W-1:0] low_r [NSTG];

  for (genvar s = 0; s < NSTG; s++) begin : g_stg
    logic [REM_W-1:0]   r_in;
    logic [MAG_W-1:0]   d_in;
    logic [RATIO_W-1:0] q_in;
    logic [RATIO_W-1:0] l_in;
    logic [REM_W-1:0]   r_v  [BPS+1];
    logic [RATIO_W-1:0] q_v  [BPS+1];
    if (s == 0) begin : g_f
      assign r_in = REM_W'(num >> 8);
      assign d_in = den;
      assign q_in = '0;
      assign l_in = {num[7:0], 24'd0};
    end else begin : g_n
      assign r_in = rem_r[s-1];
      assign d_in = den_r[s-1];
      assign q_in = q_r[s-1];
      assign l_in = low_r[s-1];
    end
    always_comb begin
      r_v[0] = r_in;
      q_v[0] = q_in;
      for (int b = 0; b < BPS; b++) begin
        logic [REM_W-1:0] sh;
        sh = {r_v[b][REM_W-2:0], l_in[RATIO_W-1-b]};
        if (sh >= {1'b0, d_in}) begin
          r_v[b+1] = sh - {1'b0, d_in};
          q_v[b+1] = {q_v[b][RATIO_W-2:0], 1'b1};
        end else begin
          r_v[b+1] = sh;
          q_v[b+1] = {q_v[b][RATIO_W-2:0], 1'b0};
        end
      end
    end
    always_ff @(posedge clk) begin
      if (en) begin
        rem_r[s] <= r_v[BPS];
        q_r[s]   <= q_v[BPS];
        den_r[s] <= d_in;
        low_r[s] <= l_in << BPS;
      end
    end
  end

  assign quot = q_r[NSTG-1];
endmodule

// ===== rtl/polynomial_partition_ratio.sv =====
// ----------------------------------------------------------------------------
// polynomial_partition_ratio
// partition function ratio p(t_ref)/p(t_amb) with a configured polynomial
// ----------------------------------------------------------------------------
// Accepts one item per clock while the output is not stalled and returns one
// result per item in order. The pipeline is 2*NUM_COEFFS horner stages (limb
// products, then sum, per step), one classify stage, sixteen divider stages
// (two quotient bits each) and the output register. The whole pipeline
// advances whenever the output register is free or being taken, so
// throughput is one item per cycle unless out_tready stalls it. The user must
// write configuration only while the pipeline is empty; the block does not enforce it.
module polynomial_partition_ratio #(
  parameter int NUM_COEFFS = 4
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        cfg_we,
  input  logic [2:0]  cfg_index,
  input  logic [47:0] cfg_wdata,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [39:0] in_tdata,   // reference_temp[19:0], ambient_temp[39:20]
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [31:0] out_tdata,  // ratio[31:0]
  output logic [1:0]  out_tuser   // status[1:0]
);
  import ppr_pkg::*;

  localparam int ACC_W = COEF_W + 28 * NUM_COEFFS;
  localparam int MAG_W = ACC_W;
  localparam int HORN_STG = 2 * NUM_COEFFS;
  localparam int DIV_STG = RATIO_W / DIV_BPS;
  localparam int LAT = HORN_STG + 1 + DIV_STG;

  // configuration
  logic mode_r;
  logic [COEF_W-1:0] coef_r [NREGS];
  logic [NUM_COEFFS*COEF_W-1:0] coefs;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mode_r <= 1'b0;
      for (int i = 0; i < NREGS; i++) coef_r[i] <= '0;
    end else if (cfg_we) begin
      unique case (cfg_index)
        REG_MODE: mode_r    <= cfg_wdata[0];
        REG_C0:   coef_r[0] <= cfg_wdata;
        REG_C1:   coef_r[1] <= cfg_wdata;
        REG_C2:   coef_r[2] <= cfg_wdata;
        REG_C3:   coef_r[3] <= cfg_wdata;
        default: ;
      endcase
    end
  end

  // orders beyond the registers read as zero
  for (genvar k = 0; k < NUM_COEFFS; k++) begin : g_coef
    if (k < NREGS) begin : g_reg
      assign coefs[k*COEF_W +: COEF_W] = coef_r[k];
    end else begin : g_zero
      assign coefs[k*COEF_W +: COEF_W] = '0;
    end
  end

  // global stall: the pipeline moves when the output slot frees
  logic adv;
  logic [LAT-1:0] vld_r;
  logic out_valid_r;
  assign adv       = !out_valid_r || out_tready;
  assign in_tready = adv;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r       <= '0;
      out_valid_r <= 1'b0;
    end else if (adv) begin
      vld_r       <= {vld_r[LAT-2:0], in_tvalid};
      out_valid_r <= vld_r[LAT-1];
    end
  end

  // horner evaluators
  logic signed [ACC_W-1:0] p_num, p_den;

  ppr_horner #(.NUM_COEFFS(NUM_COEFFS), .ACC_W(ACC_W)) u_num (
    .clk(clk), .en(adv), .t_in(in_tdata[19:0]),
    .coefs(coefs), .acc_out(p_num)
  );
  ppr_horner #(.NUM_COEFFS(NUM_COEFFS), .ACC_W(ACC_W)) u_den (
    .clk(clk), .en(adv), .t_in(in_tdata[39:20]),
    .coefs(coefs), .acc_out(p_den)
  );

  // mode travels with the item so a late write can't corrupt it
  logic [HORN_STG-1:0] mode_pipe_r;
  always_ff @(posedge clk) begin
    if (adv) mode_pipe_r <= {mode_pipe_r[HORN_STG-2:0], mode_r};
  end

  // classify stage: signs, zero checks, overflow limit, magnitudes
  logic [MAG_W-1:0] n_mag, d_mag;
  logic [MAG_W+8:0] lim;
  pre_t pre_nxt, pre_r;
  logic [MAG_W-1:0] n_mag_r, d_mag_r;

  always_comb begin
    n_mag = p_num[ACC_W-1] ? MAG_W'(-p_num) : MAG_W'(p_num);
    d_mag = p_den[ACC_W-1] ? MAG_W'(-p_den) : MAG_W'(p_den);
    lim   = {1'b0, d_mag, 8'd0};
    pre_nxt = '{done: 1'b0, status: ST_OK, ratio: '0};
    if (!mode_pipe_r[HORN_STG-1]) begin
      pre_nxt = '{done: 1'b1, status: ST_NONE, ratio: RATIO_ONE};
    end else if (p_den == '0) begin
      pre_nxt = '{done: 1'b1, status: ST_DIVZERO, ratio: RATIO_MAX};
    end else if (p_num == '0) begin
      pre_nxt = '{done: 1'b1, status: ST_OK, ratio: '0};
    end else if (p_num[ACC_W-1] != p_den[ACC_W-1]) begin
      pre_nxt = '{done: 1'b1, status: ST_SAT, ratio: '0};
    end else if ({9'd0, n_mag} >= lim) begin
      pre_nxt = '{done: 1'b1, status: ST_SAT, ratio: RATIO_MAX};
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      pre_r   <= pre_nxt;
      n_mag_r <= pre_nxt.done ? '0 : n_mag;
      d_mag_r <= pre_nxt.done ? MAG_W'(1) : d_mag;
    end
  end

  // divider, with the early decision delayed alongside
  logic [RATIO_W-1:0] quot;
  pre_t pre_d_r [DIV_STG];

  ppr_divider #(.MAG_W(MAG_W)) u_div (
    .clk(clk), .en(adv), .num(n_mag_r), .den(d_mag_r), .quot(quot)
  );

  always_ff @(posedge clk) begin
    if (adv) begin
      pre_d_r[0] <= pre_r;
      for (int i = 1; i < DIV_STG; i++) pre_d_r[i] <= pre_d_r[i-1];
    end
  end

  // output register
  logic [RATIO_W-1:0] ratio_r;
  status_t status_r;
  always_ff @(posedge clk) begin
    if (adv) begin
      ratio_r  <= pre_d_r[DIV_STG-1].done ? pre_d_r[DIV_STG-1].ratio : quot;
      status_r <= pre_d_r[DIV_STG-1].status;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = ratio_r;
  assign out_tuser  = status_r;

  // a held result must not change while stalled
  a_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid && $stable(out_tdata) && $stable(out_tuser))
    else $error("result changed while stalled");
  // mode none always reports unity
  a_none: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && out_tuser == ST_NONE |-> out_tdata == RATIO_ONE)
    else $error("mode none ratio wrong");
  // divide by zero saturates
  a_dz: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && out_tuser == ST_DIVZERO |-> out_tdata == RATIO_MAX)
    else $error("divide by zero ratio wrong");

endmodule
